// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/smlc_pkg.sv =====
// Shared types and constants of the shade motor limit controller.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package smlc_pkg;

    localparam int unsigned TICK_W                = 18;
    localparam int unsigned TICKS_PER_SECOND_DEF  = 1000;
    localparam int unsigned MAX_LIMIT_SECONDS_DEF = 150;

    // Configuration reset values
    localparam logic [7:0] RST_OPEN_LIMIT   = 8'd30;
    localparam logic [7:0] RST_CLOSE_LIMIT  = 8'd30;
    localparam logic [7:0] RST_PWM_SPEED    = 8'd255;
    localparam logic       RST_INVERT       = 1'b0;
    localparam logic       RST_ACTIVE_HIGH  = 1'b1;
    localparam logic       RST_HAS_OPEN     = 1'b1;
    localparam logic       RST_HAS_CLOSE    = 1'b1;
    localparam logic [1:0] RST_START_TARGET = 2'd0;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_INIT  = 3'd1,
        OP_OPEN  = 3'd2,
        OP_CLOSE = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OPEN    = 3'd0,
        ST_OPENING = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_CLOSING = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_shade_state;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } t_drive;

    typedef enum logic [1:0] {
        TGT_NONE   = 2'd0,
        TGT_OPEN   = 2'd1,
        TGT_CLOSED = 2'd2
    } t_target;

    typedef enum logic [2:0] {
        CFG_OPEN_LIMIT   = 3'd0,
        CFG_CLOSE_LIMIT  = 3'd1,
        CFG_PWM_SPEED    = 3'd2,
        CFG_INVERT       = 3'd3,
        CFG_ACTIVE_HIGH  = 3'd4,
        CFG_HAS_OPEN     = 3'd5,
        CFG_HAS_CLOSE    = 3'd6,
        CFG_START_TARGET = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] operation;
        logic       open_switch_level;
        logic       close_switch_level;
    } t_cmd;

    typedef struct packed {
        logic [2:0] shade_state;
        logic       drive_open_pin;
        logic       drive_close_pin;
        logic [7:0] pwm_duty;
        logic       timer_running;
        logic       report_state;
    } t_res;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] wdata;
    } t_cfg_wr;

endpackage

// ===== src/smlc_chan_if.sv =====
// Valid/ready channel carrying one request payload of type T.
// Payload types come from smlc_pkg.
`timescale 1ns / 1ps

interface smlc_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport monitor(input valid, input data, input ready);
endinterface

// ===== src/shade_motor_limit_controller.sv =====
// Shade motor limit controller: top level.
// A request is held in the input register, and its result in the result register.
// Throughput: 1 request per cycle while the result sink keeps o_res.ready high; the state update is the only loop.
// Reset (i_rst_n low, synchronous): state unknown, motor stopped, no timer, registers at defaults.
// Config port is always ready; a write takes effect on the next edge.
// Depends on smlc_pkg and smlc_chan_if.
`timescale 1ns / 1ps

module shade_motor_limit_controller #(
    parameter int unsigned TICKS_PER_SECOND  = smlc_pkg::TICKS_PER_SECOND_DEF,
    parameter int unsigned MAX_LIMIT_SECONDS = smlc_pkg::MAX_LIMIT_SECONDS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    smlc_chan_if.sink   i_cmd,
    smlc_chan_if.source o_res,
    smlc_chan_if.sink   i_cfg
);
    import smlc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_open_limit;
    logic [7:0] r_close_limit;
    logic [7:0] r_pwm_speed;
    logic       r_invert;
    logic       r_active_high;
    logic       r_has_open;
    logic       r_has_close;
    logic [1:0] r_start_target;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_limit   <= RST_OPEN_LIMIT;
            r_close_limit  <= RST_CLOSE_LIMIT;
            r_pwm_speed    <= RST_PWM_SPEED;
            r_invert       <= RST_INVERT;
            r_active_high  <= RST_ACTIVE_HIGH;
            r_has_open     <= RST_HAS_OPEN;
            r_has_close    <= RST_HAS_CLOSE;
            r_start_target <= RST_START_TARGET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.data.index))
                CFG_OPEN_LIMIT:   r_open_limit   <= i_cfg.data.wdata;
                CFG_CLOSE_LIMIT:  r_close_limit  <= i_cfg.data.wdata;
                CFG_PWM_SPEED:    r_pwm_speed    <= i_cfg.data.wdata;
                CFG_INVERT:       r_invert       <= i_cfg.data.wdata[0];
                CFG_ACTIVE_HIGH:  r_active_high  <= i_cfg.data.wdata[0];
                CFG_HAS_OPEN:     r_has_open     <= i_cfg.data.wdata[0];
                CFG_HAS_CLOSE:    r_has_close    <= i_cfg.data.wdata[0];
                CFG_START_TARGET: r_start_target <= i_cfg.data.wdata[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds the update, result register
    // holds the answer until the sink takes it. State and result advance together.
    // ------------------------------------------------------------------
    logic r_in_valid;
    t_cmd r_in;
    logic r_out_valid;
    t_res r_out;
    logic w_adv;
    logic w_in_ready;

    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_ready = !r_in_valid || w_adv;

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && w_in_ready) begin
            r_in <= i_cmd.data;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    t_shade_state              r_pos;
    logic                      r_pending;
    logic [TICK_W-1:0]         r_ticks;
    t_drive                    r_drive;

    t_shade_state              n_pos;
    logic                      n_pending;
    logic [TICK_W-1:0]         n_ticks;
    t_drive                    n_drive;
    logic                      n_report;
    t_res                      n_res;

    // Switch decode: an unfitted switch never reads as hit.
    logic w_hit_open;
    logic w_hit_close;

    assign w_hit_open  = r_has_open  && (r_in.open_switch_level  == r_active_high);
    assign w_hit_close = r_has_close && (r_in.close_switch_level == r_active_high);

    // Timeout reload: limit saturated to the max, scaled to ticks (constant multiply).
    logic [7:0]        w_open_sec;
    logic [7:0]        w_close_sec;
    logic [31:0]       w_open_prod;
    logic [31:0]       w_close_prod;
    logic [TICK_W-1:0] w_open_ticks;
    logic [TICK_W-1:0] w_close_ticks;

    assign w_open_sec    = (r_open_limit > 8'(MAX_LIMIT_SECONDS)) ?
                           8'(MAX_LIMIT_SECONDS) : r_open_limit;
    assign w_close_sec   = (r_close_limit > 8'(MAX_LIMIT_SECONDS)) ?
                           8'(MAX_LIMIT_SECONDS) : r_close_limit;
    assign w_open_prod   = 32'(w_open_sec) * 32'(TICKS_PER_SECOND);
    assign w_close_prod  = 32'(w_close_sec) * 32'(TICKS_PER_SECOND);
    assign w_open_ticks  = w_open_prod[TICK_W-1:0];
    assign w_close_ticks = w_close_prod[TICK_W-1:0];

    logic         w_expired;
    logic         w_stop;
    logic         w_start_open;
    logic         w_start_close;
    t_shade_state w_init_pos;

    // Next-state logic
    always_comb begin
        n_pos         = r_pos;
        n_pending     = r_pending;
        n_ticks       = r_ticks;
        n_drive       = r_drive;
        n_report      = 1'b0;
        w_expired     = 1'b0;
        w_stop        = 1'b0;
        w_start_open  = 1'b0;
        w_start_close = 1'b0;

        // Init position: closed switch wins over open switch.
        if (w_hit_close) begin
            w_init_pos = ST_CLOSED;
        end else if (w_hit_open) begin
            w_init_pos = ST_OPEN;
        end else begin
            w_init_pos = ST_UNKNOWN;
        end

        case (r_in.operation)
            OP_TICK: begin
                // Countdown saturates; zero with a pending timer means expired.
                if (r_pending) begin
                    if (r_ticks == '0) begin
                        w_expired = 1'b1;
                    end else begin
                        n_ticks = r_ticks - TICK_W'(1);
                    end
                end
                // Priority: open switch, open timeout, closed switch, close timeout.
                if (r_pos == ST_OPENING && w_hit_open) begin
                    n_pos  = ST_OPEN;
                    w_stop = 1'b1;
                end else if (r_pending && r_pos == ST_OPENING && w_expired) begin
                    n_pos  = r_has_open ? ST_UNKNOWN : ST_OPEN;
                    w_stop = 1'b1;
                end else if (r_pos == ST_CLOSING && w_hit_close) begin
                    n_pos  = ST_CLOSED;
                    w_stop = 1'b1;
                end else if (r_pending && r_pos == ST_CLOSING && w_expired) begin
                    n_pos  = r_has_close ? ST_UNKNOWN : ST_CLOSED;
                    w_stop = 1'b1;
                end
                if (w_stop) begin
                    n_drive   = DRV_STOP;
                    n_pending = 1'b0;
                    n_report  = 1'b1;
                end
            end
            OP_INIT: begin
                // A running motor is left alone unless a start move is asked for.
                n_pos = w_init_pos;
                if (r_start_target == TGT_OPEN && w_init_pos != ST_OPEN) begin
                    w_start_open = 1'b1;
                end else if (r_start_target == TGT_CLOSED && w_init_pos != ST_CLOSED) begin
                    w_start_close = 1'b1;
                end
                n_report = 1'b1;
            end
            OP_OPEN: begin
                if ((r_pos == ST_CLOSED && !r_pending) || (r_has_open && !w_hit_open)) begin
                    w_start_open = 1'b1;
                    n_report     = 1'b1;
                end
            end
            OP_CLOSE: begin
                if ((r_pos == ST_OPEN && !r_pending) || (r_has_close && !w_hit_close)) begin
                    w_start_close = 1'b1;
                    n_report      = 1'b1;
                end
            end
            OP_STOP: begin
                // State is kept: a stopped move stays opening/closing.
                n_drive   = DRV_STOP;
                n_pending = 1'b0;
            end
            default: ;
        endcase

        if (w_start_open) begin
            n_drive   = DRV_OPEN;
            n_ticks   = w_open_ticks;
            n_pending = 1'b1;
            n_pos     = ST_OPENING;
        end else if (w_start_close) begin
            n_drive   = DRV_CLOSE;
            n_ticks   = w_close_ticks;
            n_pending = 1'b1;
            n_pos     = ST_CLOSING;
        end
    end

    // Output decode from the updated state
    always_comb begin
        n_res.shade_state   = n_pos;
        n_res.timer_running = n_pending;
        n_res.report_state  = n_report;
        case (n_drive)
            DRV_OPEN: begin
                n_res.drive_open_pin  = ~r_invert;
                n_res.drive_close_pin = r_invert;
                n_res.pwm_duty        = r_pwm_speed;
            end
            DRV_CLOSE: begin
                n_res.drive_open_pin  = r_invert;
                n_res.drive_close_pin = ~r_invert;
                n_res.pwm_duty        = r_pwm_speed;
            end
            default: begin
                n_res.drive_open_pin  = r_invert;
                n_res.drive_close_pin = r_invert;
                n_res.pwm_duty        = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= ST_UNKNOWN;
            r_pending <= 1'b0;
            r_ticks   <= '0;
            r_drive   <= DRV_STOP;
        end else if (w_adv) begin
            r_pos     <= n_pos;
            r_pending <= n_pending;
            r_ticks   <= n_ticks;
            r_drive   <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

endmodule

// ===== src/smlc_checker.sv =====
// Port-level checker for the shade motor limit controller, bound to the top level.
// Depends on smlc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smlc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cmd_ready,
    input logic           i_res_valid,
    input logic           i_res_ready,
    input smlc_pkg::t_res i_res_data
);

    // A held result keeps its payload.
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
                 i_res_valid && $stable(i_res_data))

    // With nothing waiting at the output, requests are never refused.
    `ASSERT_IMPLIES(a_no_idle_stall, i_clk, i_rst_n, !i_res_valid, i_cmd_ready)

    // A pending timer and a driven motor always go together.
    `ASSERT_IMPLIES(a_timer_drive, i_clk, i_rst_n, i_res_valid,
                    i_res_data.timer_running ==
                    (i_res_data.drive_open_pin != i_res_data.drive_close_pin))

    // Stopped motor has zero duty.
    `ASSERT_IMPLIES(a_stop_duty, i_clk, i_rst_n,
                    i_res_valid && (i_res_data.drive_open_pin == i_res_data.drive_close_pin),
                    i_res_data.pwm_duty == 8'd0)

endmodule

bind shade_motor_limit_controller smlc_checker u_smlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
